FILE: src/lpc_pkg.sv
// Package: shared constants, codes and types of the label propagation block.
package lpc_pkg;

  // Default sizes
  localparam int unsigned MAX_NODES_DEF   = 1024;
  localparam int unsigned MAX_EDGES_DEF   = 4096;
  localparam int unsigned ROUND_LIMIT_DEF = 100;

  // Fixed field widths
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned NODE_W     = 10;
  localparam int unsigned NCOUNT_W   = 11;
  localparam int unsigned ROUNDS_W   = 7;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COMM_W     = 10;
  localparam int unsigned FOUND_W    = 11;
  localparam int unsigned EDGES_W    = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // Command codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_RANGE  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_NO_RES = 2'd3
  } status_e;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROUNDS = 2'd1;

  // Sequencer states, one-hot
  typedef enum logic [18:0] {
    ST_IDLE = 19'b1 << 0,
    ST_INIT = 19'b1 << 1,
    ST_NODE = 19'b1 << 2,
    ST_NCAP = 19'b1 << 3,
    ST_EREQ = 19'b1 << 4,
    ST_ECHK = 19'b1 << 5,
    ST_LREQ = 19'b1 << 6,
    ST_TREQ = 19'b1 << 7,
    ST_TWR  = 19'b1 << 8,
    ST_SRD  = 19'b1 << 9,
    ST_SCMP = 19'b1 << 10,
    ST_NWR  = 19'b1 << 11,
    ST_RND  = 19'b1 << 12,
    ST_MREQ = 19'b1 << 13,
    ST_MLAB = 19'b1 << 14,
    ST_MCOM = 19'b1 << 15,
    ST_RDL  = 19'b1 << 16,
    ST_RDC  = 19'b1 << 17,
    ST_DONE = 19'b1 << 18
  } state_e;

  // Edge store control
  typedef struct packed {
    logic wr;
    logic clr;
  } edge_ctl_t;

  // One result word
  typedef struct packed {
    status_e                status;
    logic [COMM_W-1:0]      community;
    logic [FOUND_W-1:0]     communities_found;
    logic [ROUNDS_W-1:0]    rounds_done;
    logic [EDGES_W-1:0]     edges_held;
  } result_t;

endpackage

FILE: src/lpc_ifs.sv
// Interfaces: command, result and register write channels.
interface lpc_in_if;
  logic                        valid;
  logic                        ready;
  logic [lpc_pkg::MODE_W-1:0]  mode;
  logic [lpc_pkg::NODE_W-1:0]  first_node;
  logic [lpc_pkg::NODE_W-1:0]  second_node;
  modport source (output valid, mode, first_node, second_node, input ready);
  modport sink (input valid, mode, first_node, second_node, output ready);
endinterface

interface lpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpc_pkg::STATUS_W-1:0]  status;
  logic [lpc_pkg::COMM_W-1:0]    community;
  logic [lpc_pkg::FOUND_W-1:0]   communities_found;
  logic [lpc_pkg::ROUNDS_W-1:0]  rounds_done;
  logic [lpc_pkg::EDGES_W-1:0]   edges_held;
  modport source (output valid, status, community, communities_found, rounds_done,
                  edges_held, input ready);
  modport sink (input valid, status, community, communities_found, rounds_done,
                edges_held, output ready);
endinterface

interface lpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lpc_pkg::CFG_IDX_W-1:0]   index;
  logic [lpc_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/lpc_edge_store.sv
// Edge store: append-only edge memory with a fill count and one read port.
module lpc_edge_store #(
  parameter int unsigned MAX_NODES = lpc_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = lpc_pkg::MAX_EDGES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lpc_pkg::edge_ctl_t                    ctl_i,
  input  logic [$clog2(MAX_NODES)-1:0]          src_i,
  input  logic [$clog2(MAX_NODES)-1:0]          tgt_i,
  input  logic [$clog2(MAX_EDGES)-1:0]          rd_addr_i,
  output logic [$clog2(MAX_NODES)-1:0]          rd_src_o,
  output logic [$clog2(MAX_NODES)-1:0]          rd_tgt_o,
  output logic [$clog2(MAX_EDGES+1)-1:0]        total_o
);
  import lpc_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_NODES);
  localparam int unsigned EAW = $clog2(MAX_EDGES);
  localparam int unsigned ETW = $clog2(MAX_EDGES+1);

  logic [2*IW-1:0] edge_mem [MAX_EDGES];
  logic [2*IW-1:0] rd_q;
  logic [ETW-1:0]  total_q, total_d;

  // fill count
  always_comb begin
    total_d = total_q;
    if (ctl_i.clr) begin
      total_d = '0;
    end else if (ctl_i.wr) begin
      total_d = total_q + ETW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

  // memory: append at the fill count, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      edge_mem[total_q[EAW-1:0]] <= {src_i, tgt_i};
    end
    rd_q <= edge_mem[rd_addr_i];
  end

  assign rd_src_o = rd_q[2*IW-1:IW];
  assign rd_tgt_o = rd_q[IW-1:0];
  assign total_o  = total_q;

endmodule

FILE: src/lpc_engine.sv
// Engine: command decode, label/tally/community memories and round sequencer.
module lpc_engine #(
  parameter int unsigned MAX_NODES   = lpc_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES   = lpc_pkg::MAX_EDGES_DEF,
  parameter int unsigned ROUND_LIMIT = lpc_pkg::ROUND_LIMIT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lpc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  input  logic [lpc_pkg::MODE_W-1:0]         in_mode_i,
  input  logic [lpc_pkg::NODE_W-1:0]         in_first_i,
  input  logic [lpc_pkg::NODE_W-1:0]         in_second_i,
  output logic                               in_ready_o,
  input  logic                               out_free_i,
  output logic                               res_load_o,
  output lpc_pkg::result_t                   res_o,
  output lpc_pkg::edge_ctl_t                 edge_ctl_o,
  output logic [$clog2(MAX_NODES)-1:0]       edge_src_o,
  output logic [$clog2(MAX_NODES)-1:0]       edge_tgt_o,
  output logic [$clog2(MAX_EDGES)-1:0]       edge_addr_o,
  input  logic [$clog2(MAX_NODES)-1:0]       edge_src_i,
  input  logic [$clog2(MAX_NODES)-1:0]       edge_tgt_i,
  input  logic [$clog2(MAX_EDGES+1)-1:0]     edge_total_i
);
  import lpc_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_NODES);
  localparam int unsigned NW  = $clog2(MAX_NODES+1);
  localparam int unsigned EAW = $clog2(MAX_EDGES);
  localparam int unsigned ETW = $clog2(MAX_EDGES+1);
  localparam int unsigned RW  = $clog2(ROUND_LIMIT+1);
  localparam int unsigned TW  = $clog2(2*MAX_EDGES+1);

  // memories
  logic [IW-1:0] lab_mem   [2**(IW+1)];
  logic [TW-1:0] tally_mem [MAX_NODES];
  logic [IW:0]   comm_mem  [MAX_NODES];

  logic          lab_we, tal_we, com_we;
  logic [IW:0]   lab_ra, lab_wa;
  logic [IW-1:0] lab_wd, lab_rd_q;
  logic [IW-1:0] tal_ra, tal_wa, com_ra, com_wa;
  logic [TW-1:0] tal_wd, tal_rd_q;
  logic [IW:0]   com_wd, com_rd_q;

  // control and payload registers
  state_e                state_q, state_d;
  logic [NCOUNT_W-1:0]   num_nodes_q, num_nodes_d;
  logic [ROUNDS_W-1:0]   max_rounds_q, max_rounds_d;
  logic                  valid_q, valid_d;
  logic                  sel_q, sel_d;
  logic [RW-1:0]         rounds_q, rounds_d;
  logic [NW-1:0]         total_q, total_d;
  logic [IW-1:0]         i_q, i_d, lbl_q, lbl_d, nbr_q, nbr_d, lab_q, lab_d;
  logic [IW-1:0]         cur_lab_q, cur_lab_d, best_q, best_d, comm_q, comm_d;
  logic [ETW-1:0]        e_q, e_d;
  logic [TW-1:0]         best_cnt_q, best_cnt_d;
  logic                  has_nbr_q, has_nbr_d, pend2_q, pend2_d, changed_q, changed_d;

  logic [NW-1:0]         n_eff;
  logic [RW-1:0]         lim;
  logic                  accept, i_last, edge_in;

  // clamped register values
  always_comb begin
    if (num_nodes_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(num_nodes_q) > MAX_NODES) begin
      n_eff = NW'(MAX_NODES);
    end else begin
      n_eff = NW'(num_nodes_q);
    end
    if (max_rounds_q == '0) begin
      lim = RW'(1);
    end else if (32'(max_rounds_q) > ROUND_LIMIT) begin
      lim = RW'(ROUND_LIMIT);
    end else begin
      lim = RW'(max_rounds_q);
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE) && out_free_i;
  assign accept      = in_valid_i && in_ready_o;
  assign i_last      = (32'(i_q) + 32'd1) == 32'(n_eff);
  assign edge_in     = (32'(edge_src_i) < 32'(n_eff)) && (32'(edge_tgt_i) < 32'(n_eff));
  assign edge_src_o  = IW'(in_first_i);
  assign edge_tgt_o  = IW'(in_second_i);
  assign edge_addr_o = e_q[EAW-1:0];

  // sequencer
  always_comb begin
    state_d      = state_q;
    num_nodes_d  = num_nodes_q;
    max_rounds_d = max_rounds_q;
    valid_d      = valid_q;
    sel_d        = sel_q;
    rounds_d     = rounds_q;
    total_d      = total_q;
    i_d          = i_q;
    lbl_d        = lbl_q;
    nbr_d        = nbr_q;
    lab_d        = lab_q;
    cur_lab_d    = cur_lab_q;
    best_d       = best_q;
    comm_d       = comm_q;
    e_d          = e_q;
    best_cnt_d   = best_cnt_q;
    has_nbr_d    = has_nbr_q;
    pend2_d      = pend2_q;
    changed_d    = changed_q;

    lab_we = 1'b0; lab_wa = '0; lab_wd = '0; lab_ra = {sel_q, i_q};
    tal_we = 1'b0; tal_wa = '0; tal_wd = '0; tal_ra = lbl_q;
    com_we = 1'b0; com_wa = '0; com_wd = '0; com_ra = lab_rd_q;

    edge_ctl_o = '0;
    res_load_o = 1'b0;
    res_o.status            = STAT_OK;
    res_o.community         = '0;
    res_o.communities_found = FOUND_W'(total_q);
    res_o.rounds_done       = ROUNDS_W'(rounds_q);
    res_o.edges_held        = EDGES_W'(edge_total_i);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_e'(in_mode_i))
            MODE_ADD: begin
              res_load_o = 1'b1;
              if (32'(in_first_i) >= 32'(n_eff) || 32'(in_second_i) >= 32'(n_eff)) begin
                res_o.status = STAT_RANGE;
              end else if (32'(edge_total_i) == MAX_EDGES) begin
                res_o.status = STAT_FULL;
              end else begin
                edge_ctl_o.wr    = 1'b1;
                res_o.edges_held = EDGES_W'(32'(edge_total_i) + 32'd1);
              end
            end
            MODE_RUN: begin
              i_d     = '0;
              state_d = ST_INIT;
            end
            MODE_READ: begin
              if (!valid_q) begin
                res_load_o   = 1'b1;
                res_o.status = STAT_NO_RES;
              end else if (32'(in_first_i) >= 32'(n_eff)) begin
                res_load_o   = 1'b1;
                res_o.status = STAT_RANGE;
              end else begin
                lab_ra  = {sel_q, IW'(in_first_i)};
                state_d = ST_RDL;
              end
            end
            default: begin
              edge_ctl_o.clr   = 1'b1;
              res_load_o       = 1'b1;
              res_o.edges_held = '0;
            end
          endcase
        end
      end
      // own index as label, clear tally and community marks
      ST_INIT: begin
        lab_we = 1'b1; lab_wa = {sel_q, i_q}; lab_wd = i_q;
        tal_we = 1'b1; tal_wa = i_q; tal_wd = '0;
        com_we = 1'b1; com_wa = i_q; com_wd = '0;
        if (i_last) begin
          i_d       = '0;
          rounds_d  = '0;
          changed_d = 1'b0;
          state_d   = ST_NODE;
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      ST_NODE: begin
        lab_ra    = {sel_q, i_q};
        e_d       = '0;
        has_nbr_d = 1'b0;
        state_d   = ST_NCAP;
      end
      ST_NCAP: begin
        cur_lab_d = lab_rd_q;
        state_d   = ST_EREQ;
      end
      // walk the edge list for node i
      ST_EREQ: begin
        if (e_q == edge_total_i) begin
          best_d = cur_lab_q;
          if (has_nbr_q) begin
            lbl_d      = '0;
            best_cnt_d = '0;
            state_d    = ST_SRD;
          end else begin
            state_d = ST_NWR;
          end
        end else begin
          state_d = ST_ECHK;
        end
      end
      ST_ECHK: begin
        if (edge_in && edge_src_i == i_q) begin
          nbr_d     = edge_tgt_i;
          pend2_d   = (edge_tgt_i == i_q);
          has_nbr_d = 1'b1;
          state_d   = ST_LREQ;
        end else if (edge_in && edge_tgt_i == i_q) begin
          nbr_d     = edge_src_i;
          pend2_d   = 1'b0;
          has_nbr_d = 1'b1;
          state_d   = ST_LREQ;
        end else begin
          e_d     = e_q + ETW'(1);
          state_d = ST_EREQ;
        end
      end
      ST_LREQ: begin
        lab_ra  = {sel_q, nbr_q};
        state_d = ST_TREQ;
      end
      ST_TREQ: begin
        tal_ra  = lab_rd_q;
        lab_d   = lab_rd_q;
        state_d = ST_TWR;
      end
      // tally read-modify-write; a self-loop counts twice
      ST_TWR: begin
        tal_we = 1'b1; tal_wa = lab_q; tal_wd = tal_rd_q + TW'(1);
        if (pend2_q) begin
          pend2_d = 1'b0;
          state_d = ST_LREQ;
        end else begin
          e_d     = e_q + ETW'(1);
          state_d = ST_EREQ;
        end
      end
      // scan tallies ascending: strict compare keeps the lowest label on ties
      ST_SRD: begin
        tal_ra  = lbl_q;
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        if (tal_rd_q > best_cnt_q) begin
          best_d     = lbl_q;
          best_cnt_d = tal_rd_q;
        end
        tal_we = 1'b1; tal_wa = lbl_q; tal_wd = '0;
        if ((32'(lbl_q) + 32'd1) == 32'(n_eff)) begin
          state_d = ST_NWR;
        end else begin
          lbl_d   = lbl_q + IW'(1);
          state_d = ST_SRD;
        end
      end
      ST_NWR: begin
        lab_we = 1'b1; lab_wa = {~sel_q, i_q}; lab_wd = best_q;
        if (best_q != cur_lab_q) begin
          changed_d = 1'b1;
        end
        if (i_last) begin
          state_d = ST_RND;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = ST_NODE;
        end
      end
      // end of round: swap banks, stop on limit or no change
      ST_RND: begin
        rounds_d = rounds_q + RW'(1);
        sel_d    = ~sel_q;
        i_d      = '0;
        if (!changed_q || (32'(rounds_q) + 32'd1) >= 32'(lim)) begin
          total_d = '0;
          state_d = ST_MREQ;
        end else begin
          changed_d = 1'b0;
          state_d   = ST_NODE;
        end
      end
      // number communities by first appearance
      ST_MREQ: begin
        lab_ra  = {sel_q, i_q};
        state_d = ST_MLAB;
      end
      ST_MLAB: begin
        com_ra  = lab_rd_q;
        lab_d   = lab_rd_q;
        state_d = ST_MCOM;
      end
      ST_MCOM: begin
        if (!com_rd_q[IW]) begin
          com_we  = 1'b1; com_wa = lab_q; com_wd = {1'b1, IW'(total_q)};
          total_d = total_q + NW'(1);
        end
        if (i_last) begin
          valid_d = 1'b1;
          comm_d  = '0;
          state_d = ST_DONE;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = ST_MREQ;
        end
      end
      ST_RDL: begin
        com_ra  = lab_rd_q;
        state_d = ST_RDC;
      end
      ST_RDC: begin
        comm_d  = com_rd_q[IW-1:0];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        res_o.community = COMM_W'(comm_q);
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register writes; the host issues them only while idle
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_NUM_NODES) begin
        num_nodes_d = cfg_data_i[NCOUNT_W-1:0];
        valid_d     = 1'b0;
      end else if (cfg_index_i == CFG_MAX_ROUNDS) begin
        max_rounds_d = cfg_data_i[ROUNDS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      num_nodes_q  <= NCOUNT_W'(1);
      max_rounds_q <= ROUNDS_W'(10);
      valid_q      <= 1'b0;
      sel_q        <= 1'b0;
      rounds_q     <= '0;
      total_q      <= '0;
      i_q          <= '0;
      lbl_q        <= '0;
      e_q          <= '0;
      has_nbr_q    <= 1'b0;
      pend2_q      <= 1'b0;
      changed_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      num_nodes_q  <= num_nodes_d;
      max_rounds_q <= max_rounds_d;
      valid_q      <= valid_d;
      sel_q        <= sel_d;
      rounds_q     <= rounds_d;
      total_q      <= total_d;
      i_q          <= i_d;
      lbl_q        <= lbl_d;
      e_q          <= e_d;
      has_nbr_q    <= has_nbr_d;
      pend2_q      <= pend2_d;
      changed_q    <= changed_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    nbr_q      <= nbr_d;
    lab_q      <= lab_d;
    cur_lab_q  <= cur_lab_d;
    best_q     <= best_d;
    best_cnt_q <= best_cnt_d;
    comm_q     <= comm_d;
  end

  // label memory, two banks
  always_ff @(posedge clk_i) begin
    if (lab_we) begin
      lab_mem[lab_wa] <= lab_wd;
    end
    lab_rd_q <= lab_mem[lab_ra];
  end

  // tally memory
  always_ff @(posedge clk_i) begin
    if (tal_we) begin
      tally_mem[tal_wa] <= tal_wd;
    end
    tal_rd_q <= tally_mem[tal_ra];
  end

  // community memory: seen mark and number
  always_ff @(posedge clk_i) begin
    if (com_we) begin
      comm_mem[com_wa] <= com_wd;
    end
    com_rd_q <= comm_mem[com_ra];
  end

endmodule

FILE: src/label_propagation_communities.sv
// Top level: label propagation community detection over a stored edge list.
//
// Channels: in_i takes command words (add edge, run, read community, clear
// edges); out_o gives one result word per command; cfg_i writes the node
// count register (index 0) and max_rounds (index 1) and is always ready; the
// host must write only while idle, which the block itself does not enforce.
// Add edge and clear finish in the accept cycle: one word per cycle as long
// as out_o is taken. A read looks up the label memory, then the community
// memory. A run sets every node's label to its own index, then in each round
// walks the stored edge list once per node, tallying neighbor labels (a
// self-loop counts twice), scans the tally of every label for nodes with
// neighbors, and writes the new label; after the last round it numbers the
// communities by first appearance.
// No command is taken while a run or read is in progress.
// Results sit in an output register; while out_o stalls, commands are held
// off. Reset clears the edge count, sets the node count register to 1 and
// max_rounds to 10, and marks results as not yet available. No clearing pass.
module label_propagation_communities #(
  parameter int unsigned MAX_NODES   = lpc_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES   = lpc_pkg::MAX_EDGES_DEF,
  parameter int unsigned ROUND_LIMIT = lpc_pkg::ROUND_LIMIT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpc_in_if.sink     in_i,
  lpc_out_if.source  out_o,
  lpc_cfg_if.sink    cfg_i
);
  import lpc_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_NODES);
  localparam int unsigned EAW = $clog2(MAX_EDGES);
  localparam int unsigned ETW = $clog2(MAX_EDGES+1);

  edge_ctl_t      edge_ctl;
  logic [IW-1:0]  wr_src, wr_tgt, rd_src, rd_tgt;
  logic [EAW-1:0] rd_addr;
  logic [ETW-1:0] edge_total;
  logic           out_free, res_load;
  result_t        res, res_q;
  logic           out_valid_q, out_valid_d;

  assign cfg_i.ready = 1'b1;

  lpc_edge_store #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_edges (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (edge_ctl),
    .src_i     (wr_src),
    .tgt_i     (wr_tgt),
    .rd_addr_i (rd_addr),
    .rd_src_o  (rd_src),
    .rd_tgt_o  (rd_tgt),
    .total_o   (edge_total)
  );

  lpc_engine #(
    .MAX_NODES   (MAX_NODES),
    .MAX_EDGES   (MAX_EDGES),
    .ROUND_LIMIT (ROUND_LIMIT)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .in_valid_i   (in_i.valid),
    .in_mode_i    (in_i.mode),
    .in_first_i   (in_i.first_node),
    .in_second_i  (in_i.second_node),
    .in_ready_o   (in_i.ready),
    .out_free_i   (out_free),
    .res_load_o   (res_load),
    .res_o        (res),
    .edge_ctl_o   (edge_ctl),
    .edge_src_o   (wr_src),
    .edge_tgt_o   (wr_tgt),
    .edge_addr_o  (rd_addr),
    .edge_src_i   (rd_src),
    .edge_tgt_i   (rd_tgt),
    .edge_total_i (edge_total)
  );

  // output register
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status            = res_q.status;
  assign out_o.community         = res_q.community;
  assign out_o.communities_found = res_q.communities_found;
  assign out_o.rounds_done       = res_q.rounds_done;
  assign out_o.edges_held        = res_q.edges_held;

  // checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> out_free)
    else $error("result loaded over an untaken word");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.mode == MODE_RUN |=> !in_i.ready)
    else $error("command taken during a run");

  a_comm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != STAT_OK |-> out_o.community == '0)
    else $error("community set on a failed command");

  a_edges_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> 32'(out_o.edges_held) <= MAX_EDGES)
    else $error("edge count beyond store depth");

endmodule
